>>> sv/matrix_keypad_debounce_scanner_core_macros.svh
// Assertion helpers for the keypad scanner checks.
// Each expects clk and arst_n in the scope that uses it.
`ifndef MATRIX_KEYPAD_DEBOUNCE_SCANNER_CORE_MACROS_SVH
`define MATRIX_KEYPAD_DEBOUNCE_SCANNER_CORE_MACROS_SVH

// same-cycle implication
`define KP_ASSERT_SAME(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("keypad scanner check failed");

// next-cycle implication
`define KP_ASSERT_NEXT(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("keypad scanner check failed");

`endif

>>> sv/mkds_pkg.sv
package mkds_pkg;

	localparam int COL_W  = 5;
	localparam int ROW_W  = 4;
	localparam int CODE_W = 5;
	localparam int CFG_W  = 8;
	localparam int IDX_W  = 2;

	localparam int ROWS_DEF    = 4;
	localparam int COLUMNS_DEF = 5;

	localparam logic [CFG_W-1:0] WINDOW_RST = 8'd10;
	localparam logic [CFG_W-1:0] ON_RST     = 8'd7;
	localparam logic [CFG_W-1:0] OFF_RST    = 8'd3;
	localparam logic [CFG_W-1:0] SUM_MAX    = 8'hFF;

	localparam logic [IDX_W-1:0] REG_WINDOW = 2'd0;
	localparam logic [IDX_W-1:0] REG_ON     = 2'd1;
	localparam logic [IDX_W-1:0] REG_OFF    = 2'd2;

	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_READ = 1'b1;

	typedef struct packed {
		logic             mode;
		logic [COL_W-1:0] col_lines;
		logic [ROW_W-1:0] row_hits;
	} req_t;

	typedef struct packed {
		logic [CODE_W-1:0] key_code;
		logic              key_ready;
		logic              key_down;
	} rsp_t;

	function automatic logic [2:0] highest_col(input logic [COL_W-1:0] v);
		logic [2:0] idx;
		idx = '0;
		for (int i = 0; i < COL_W; i++) begin
			if (v[i]) idx = 3'(i);
		end
		return idx;
	endfunction

	function automatic logic [1:0] highest_row(input logic [ROW_W-1:0] v);
		logic [1:0] idx;
		idx = '0;
		for (int i = 0; i < ROW_W; i++) begin
			if (v[i]) idx = 2'(i);
		end
		return idx;
	endfunction

endpackage

>>> sv/mkds_if.sv
interface mkds_req_if;
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [mkds_pkg::COL_W-1:0]  col_lines;
	logic [mkds_pkg::ROW_W-1:0]  row_hits;

	modport source(output valid, mode, col_lines, row_hits, input ready);
	modport sink(input valid, mode, col_lines, row_hits, output ready);
endinterface

interface mkds_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [mkds_pkg::CODE_W-1:0] key_code;
	logic                        key_ready;
	logic                        key_down;

	modport source(output valid, key_code, key_ready, key_down, input ready);
	modport sink(input valid, key_code, key_ready, key_down, output ready);
endinterface

interface mkds_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [mkds_pkg::IDX_W-1:0]  index;
	logic [mkds_pkg::CFG_W-1:0]  data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> sv/mkds_debounce.sv
module mkds_debounce #(
	parameter int ROWS    = mkds_pkg::ROWS_DEF,
	parameter int COLUMNS = mkds_pkg::COLUMNS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	mkds_cfg_if.sink       cfg,
	input  logic           take,
	input  mkds_pkg::req_t item,
	output mkds_pkg::rsp_t rsp_d
);
	import mkds_pkg::*;

	logic [CFG_W-1:0]  window_q, on_thr_q, off_thr_q;
	logic [CFG_W-1:0]  tick_count_q, press_sum_q;
	logic              down_q, ready_q;
	logic [CODE_W-1:0] code_q;

	logic [COL_W-1:0]  col_mask, low_cols;
	logic [ROW_W-1:0]  row_mask, hit_rows;
	logic [CFG_W-1:0]  sum_inc, cnt_inc;
	logic              win_close, on_hit, down_mid, store;
	logic [CODE_W-1:0] code_new;

	logic [CFG_W-1:0]  tick_count_n, press_sum_n;
	logic              down_n, ready_n, ready_out;
	logic [CODE_W-1:0] code_n;

	for (genvar i = 0; i < COL_W; i++) begin : g_col_mask
		assign col_mask[i] = (i < COLUMNS);
	end
	for (genvar i = 0; i < ROW_W; i++) begin : g_row_mask
		assign row_mask[i] = (i < ROWS);
	end

	assign cfg.ready = 1'b1;

	always_comb begin
		low_cols  = ~item.col_lines & col_mask;
		hit_rows  = item.row_hits & row_mask;
		sum_inc   = press_sum_q + CFG_W'((|low_cols) && (press_sum_q != SUM_MAX));
		cnt_inc   = tick_count_q + CFG_W'(1);
		win_close = (cnt_inc >= window_q);
		on_hit    = win_close && (sum_inc >= on_thr_q) && !down_q;
		down_mid  = on_hit | down_q;
		store     = on_hit && (|low_cols) && (|hit_rows);
		code_new  = CODE_W'(COLUMNS * int'(highest_row(hit_rows))
			+ int'(highest_col(low_cols)));

		tick_count_n = tick_count_q;
		press_sum_n  = press_sum_q;
		down_n       = down_q;
		ready_n      = ready_q;
		code_n       = code_q;
		ready_out    = ready_q;

		unique case (item.mode)
			MODE_READ: begin
				ready_n = 1'b0;
			end
			MODE_TICK: begin
				tick_count_n = win_close ? '0 : cnt_inc;
				press_sum_n  = win_close ? '0 : sum_inc;
				down_n       = (win_close && (sum_inc <= off_thr_q)) ? 1'b0 : down_mid;
				if (store) begin
					ready_n = 1'b1;
					code_n  = code_new;
				end
				ready_out = ready_n;
			end
			default: ;
		endcase

		rsp_d = '{key_code: code_n, key_ready: ready_out, key_down: down_n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= WINDOW_RST;
			on_thr_q     <= ON_RST;
			off_thr_q    <= OFF_RST;
			tick_count_q <= '0;
			press_sum_q  <= '0;
			down_q       <= 1'b1;
			ready_q      <= 1'b0;
			code_q       <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_WINDOW: window_q  <= cfg.data;
					REG_ON:     on_thr_q  <= cfg.data;
					REG_OFF:    off_thr_q <= cfg.data;
					default: ;
				endcase
			end
			if (take) begin
				tick_count_q <= tick_count_n;
				press_sum_q  <= press_sum_n;
				down_q       <= down_n;
				ready_q      <= ready_n;
				code_q       <= code_n;
			end
		end
	end

endmodule

>>> sv/mkds_out_reg.sv
module mkds_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  mkds_pkg::rsp_t rsp_d,
	input  logic           out_ready,
	output logic           out_valid,
	output mkds_pkg::rsp_t rsp_q,
	output logic           in_ready
);
	import mkds_pkg::*;

	logic valid_q;

	// free slot, or the held result leaves this cycle
	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

>>> sv/matrix_keypad_debounce_scanner_core.sv
// Keypad scanner with integrating debounce.
// A result is valid in the cycle after its item transfers.
// Throughput: one item per cycle while the output is not stalled; the single
// output register takes a new result in the same cycle the held one transfers out.
// Reset (arst_n low): window 10, thresholds 7 and 3, counters clear,
// key considered down, no key ready, buffered code 0, no result pending.
module matrix_keypad_debounce_scanner_core #(
	parameter int ROWS    = mkds_pkg::ROWS_DEF,
	parameter int COLUMNS = mkds_pkg::COLUMNS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	mkds_req_if.sink  req,
	mkds_rsp_if.source rsp,
	mkds_cfg_if.sink  cfg
);
	import mkds_pkg::*;

	req_t item;
	rsp_t rsp_d, rsp_q;
	logic take, in_ready, out_valid;

	assign item = '{mode: req.mode, col_lines: req.col_lines, row_hits: req.row_hits};
	assign take = req.valid && in_ready;
	assign req.ready = in_ready;

	mkds_debounce #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS)
	) u_debounce (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.take   (take),
		.item   (item),
		.rsp_d  (rsp_d)
	);

	mkds_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.rsp_d     (rsp_d),
		.out_ready (rsp.ready),
		.out_valid (out_valid),
		.rsp_q     (rsp_q),
		.in_ready  (in_ready)
	);

	assign rsp.valid     = out_valid;
	assign rsp.key_code  = rsp_q.key_code;
	assign rsp.key_ready = rsp_q.key_ready;
	assign rsp.key_down  = rsp_q.key_down;

endmodule

>>> sv/mkds_checker.sv
`include "matrix_keypad_debounce_scanner_core_macros.svh"

module mkds_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        req_mode,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [mkds_pkg::CODE_W-1:0] rsp_key_code,
	input logic                        rsp_key_ready
);
	import mkds_pkg::*;

	logic req_xfer, read_xfer;

	assign req_xfer  = req_valid && req_ready;
	assign read_xfer = req_xfer && (req_mode == MODE_READ);

	// every accepted item yields a result on the next cycle
	`KP_ASSERT_NEXT(a_result_follows, req_xfer, rsp_valid)
	// a read right after a read finds the flag already cleared
	`KP_ASSERT_NEXT(a_double_read, read_xfer ##1 read_xfer, !rsp_key_ready)
	// an empty output stage never stalls the input
	`KP_ASSERT_SAME(a_empty_accepts, !rsp_valid, req_ready)
	// a stalled result holds
	`KP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_key_code))

endmodule

bind matrix_keypad_debounce_scanner_core mkds_checker u_mkds_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_mode      (req.mode),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_key_code  (rsp.key_code),
	.rsp_key_ready (rsp.key_ready)
);
